// File: design/flow_stats_rtp_jitter_defines.svh
// assertion macros for the flow statistics block
// used by the top level and the divider, no other dependencies
`ifndef FLOW_STATS_RTP_JITTER_DEFINES_SVH
`define FLOW_STATS_RTP_JITTER_DEFINES_SVH

// generic clocked assertion with asynchronous active-low reset
`define FSRJ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// shorthand on the usual clock and reset names
`define FSRJ_ASSERT(label, prop, msg) `FSRJ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: design/fsrj_pkg.sv
// shared constants, event codes and divider handshake types
// no dependencies
`default_nettype none

package fsrj_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int COUNT_BITS_DEF = 32;
  localparam int DSUM_BITS      = 64;
  localparam int OUT_CNT_BITS   = 32;
  localparam int BYTE_BITS      = 16;
  localparam int FUNC_BITS      = 2;
  localparam int JITTER_SHIFT   = 4;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_TX  = 2'd0,
    FUNC_RX  = 2'd1,
    FUNC_CLR = 2'd2,
    FUNC_NOP = 2'd3
  } func_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: design/fsrj_if.sv
// event and result channel interfaces, valid/ready handshake
// depends on fsrj_pkg
`default_nettype none

interface fsrj_evt_if #(
  parameter int TIME_BITS = fsrj_pkg::TIME_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic [fsrj_pkg::FUNC_BITS-1:0]     func;
  logic [fsrj_pkg::BYTE_BITS-1:0]     byte_count;
  logic [TIME_BITS-1:0]               now_time;
  logic [TIME_BITS-1:0]               sent_time;

  modport source (output valid, func, byte_count, now_time, sent_time, input ready);
  modport sink   (input valid, func, byte_count, now_time, sent_time, output ready);
endinterface

interface fsrj_res_if #(
  parameter int TIME_BITS = fsrj_pkg::TIME_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [fsrj_pkg::OUT_CNT_BITS-1:0] tx_index;
  logic [fsrj_pkg::OUT_CNT_BITS-1:0] tx_packets;
  logic [fsrj_pkg::OUT_CNT_BITS-1:0] tx_bytes;
  logic [fsrj_pkg::OUT_CNT_BITS-1:0] rx_packets;
  logic [fsrj_pkg::OUT_CNT_BITS-1:0] rx_bytes;
  logic [fsrj_pkg::OUT_CNT_BITS-1:0] lost_packets;
  logic [TIME_BITS-1:0]              jitter;
  logic [TIME_BITS-1:0]              mean_delay;
  logic signed [TIME_BITS:0]         active_time;

  modport source (output valid, tx_index, tx_packets, tx_bytes, rx_packets, rx_bytes,
                  lost_packets, jitter, mean_delay, active_time, input ready);
  modport sink   (input valid, tx_index, tx_packets, tx_bytes, rx_packets, rx_bytes,
                  lost_packets, jitter, mean_delay, active_time, output ready);
endinterface

`default_nettype wire

// File: design/fsrj_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on fsrj_pkg and the assertion macro header
`default_nettype none

`include "flow_stats_rtp_jitter_defines.svh"

module fsrj_div #(
  parameter int NUM_BITS = fsrj_pkg::DSUM_BITS,
  parameter int DEN_BITS = fsrj_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fsrj_pkg::div_ctrl_t   ctrl_i,
  input  logic [NUM_BITS-1:0]   num_i,
  input  logic [DEN_BITS-1:0]   den_i,
  output fsrj_pkg::div_stat_t   stat_o,
  output logic [NUM_BITS-1:0]   quo_o
);

  localparam int CNT_W = $clog2(NUM_BITS);

  logic                busy_q, done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [NUM_BITS-1:0] quo_q, quo_d;
  logic [DEN_BITS-1:0] rem_q, rem_d;
  logic [DEN_BITS-1:0] den_q;
  logic [DEN_BITS:0]   rem_sh;
  logic [DEN_BITS+1:0] trial;
  logic                fits;
  logic                last;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign rem_sh = {rem_q, quo_q[NUM_BITS-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign fits   = ~trial[DEN_BITS+1];
  assign rem_d  = fits ? trial[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
  assign quo_d  = {quo_q[NUM_BITS-2:0], fits};
  assign last   = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q & last;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_BITS - 1);
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

  `FSRJ_ASSERT(a_div_start_idle, ctrl_i.start |-> !busy_q, "divider started while busy")
  `FSRJ_ASSERT(a_div_start_busy, ctrl_i.start |=> busy_q, "divider did not go busy")
  `FSRJ_ASSERT(a_div_last_done, busy_q && last && !ctrl_i.start |=> done_q && !busy_q,
               "divider missed its done pulse")

endmodule

`default_nettype wire

// File: design/flow_stats_rtp_jitter.sv
// Per-flow packet statistics with an RTP interarrival jitter estimate.
// Each accepted item is updated and then runs the radix-2 mean-delay divider (one quotient
// bit per cycle over 64 bits) before its result is registered; a receive first runs the
// bit-serial pass and four jitter steps. One item at a time: no new item is accepted until
// its result is loaded into the output register, which waits while the output stalls.
// Reset clears all counters, times, jitter and delay sum to zero and empties the output.
`default_nettype none

`include "flow_stats_rtp_jitter_defines.svh"

module flow_stats_rtp_jitter #(
  parameter int TIME_BITS  = fsrj_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = fsrj_pkg::COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fsrj_evt_if.sink  evt_i,
  fsrj_res_if.source res_o
);

  // serial pass length: covers the 64-bit delay sum and the signed jitter difference
  localparam int SER_BITS = (TIME_BITS + 2 > fsrj_pkg::DSUM_BITS) ?
                            TIME_BITS + 2 : fsrj_pkg::DSUM_BITS;
  localparam int SCNT_W   = $clog2(SER_BITS);
  localparam int XW       = (COUNT_BITS > fsrj_pkg::OUT_CNT_BITS) ?
                            COUNT_BITS : fsrj_pkg::OUT_CNT_BITS;
  localparam int JS       = fsrj_pkg::JITTER_SHIFT;
  localparam int JROUND   = (1 << JS) - 1;
  localparam int DW       = fsrj_pkg::DSUM_BITS;
  localparam int OW       = fsrj_pkg::OUT_CNT_BITS;

  // one-hot sequencer states
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_UPD   = 10'b0000000010,
    S_SER   = 10'b0000000100,
    S_MAG   = 10'b0000001000,
    S_JDIF  = 10'b0000010000,
    S_JSTEP = 10'b0000100000,
    S_JUPD  = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_DWAIT = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  // widen or trim a counter onto a result field
  function automatic logic [OW-1:0] to_out(input logic [COUNT_BITS-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return w[OW-1:0];
  endfunction

  state_e state_q, state_d;

  // flow state
  logic [COUNT_BITS-1:0] tx_cnt_q, tx_byt_q, rx_cnt_q, rx_byt_q;
  logic [TIME_BITS-1:0]  first_tx_q, last_rx_q, last_stamp_q, jit_q;
  logic [DW-1:0]         dsum_q;

  // captured item
  fsrj_pkg::func_e       func_q;
  logic [COUNT_BITS-1:0] bytes_q;
  logic [TIME_BITS-1:0]  now_q, sent_q;

  // bit-serial operands and results, lsb first
  logic [SER_BITS-1:0]   now_sh_q, sent_sh_q, rx_sh_q, stamp_sh_q, dsum_sh_q;
  logic [SER_BITS-1:0]   d_sh_q, cand_sh_q;
  logic                  ca_q, cb_q, bd_q, bw_q, cc_q;
  logic [SCNT_W-1:0]     scnt_q;

  // jitter update pipeline
  logic [TIME_BITS-1:0]  mag_q, jd_q, step_q;
  logic                  ge_q;

  // output register
  logic                  out_valid_q, out_valid_d, out_load;
  logic [OW-1:0]         o_txi_q, o_txp_q, o_txb_q, o_rxp_q, o_rxb_q, o_lost_q;
  logic [TIME_BITS-1:0]  o_jit_q, o_mean_q;
  logic [TIME_BITS:0]    o_act_q;

  // divider
  fsrj_pkg::div_ctrl_t   div_ctrl;
  fsrj_pkg::div_stat_t   div_stat;
  logic [DW-1:0]         quo;

  // serial bit slice
  logic a_b, ca_d, b_b, cb_d, d_b, bd_d, dl_b, bw_d, c_b, cc_d;
  logic n_b, s_b, r_b, t_b, z_b;

  // wide combinational helpers
  logic [COUNT_BITS-1:0] tx_inc;
  logic [SER_BITS-1:0]   abs_v;
  logic [TIME_BITS-1:0]  mag_d;
  logic [TIME_BITS:0]    sub_mj;
  logic [TIME_BITS:0]    rnd;
  logic [COUNT_BITS-1:0] lost_v;
  logic [TIME_BITS-1:0]  mean_v;
  logic [TIME_BITS:0]    act_v;
  logic                  ser_last;

  assign evt_i.ready = (state_q == S_IDLE);

  // ---------------------------------------------------------------------------
  // serial slice: a = now + stamp, b = rx + sent, d = a - b (signed jitter delta),
  // and candidate delay sum = dsum + (now - sent); the final borrow of now - sent
  // tells whether the delay was negative and the candidate is thrown away
  // ---------------------------------------------------------------------------
  assign n_b  = now_sh_q[0];
  assign s_b  = sent_sh_q[0];
  assign r_b  = rx_sh_q[0];
  assign t_b  = stamp_sh_q[0];
  assign z_b  = dsum_sh_q[0];

  assign a_b  = n_b ^ t_b ^ ca_q;
  assign ca_d = (n_b & t_b) | (ca_q & (n_b ^ t_b));
  assign b_b  = r_b ^ s_b ^ cb_q;
  assign cb_d = (r_b & s_b) | (cb_q & (r_b ^ s_b));
  assign d_b  = a_b ^ b_b ^ bd_q;
  assign bd_d = (~a_b & b_b) | (~(a_b ^ b_b) & bd_q);
  assign dl_b = n_b ^ s_b ^ bw_q;
  assign bw_d = (~n_b & s_b) | (~(n_b ^ s_b) & bw_q);
  assign c_b  = z_b ^ dl_b ^ cc_q;
  assign cc_d = (z_b & dl_b) | (cc_q & (z_b ^ dl_b));

  assign ser_last = (scnt_q == SCNT_W'(SER_BITS - 1));

  // magnitude of the delta, saturated onto the time width
  assign abs_v = d_sh_q[SER_BITS-1] ? (~d_sh_q + 1'b1) : d_sh_q;
  assign mag_d = (|abs_v[SER_BITS-1:TIME_BITS]) ? '1 : abs_v[TIME_BITS-1:0];

  // jitter: sign of mag - j, then the rounded step toward mag
  assign sub_mj = {1'b0, mag_q} - {1'b0, jit_q};
  assign rnd    = {1'b0, jd_q} + (TIME_BITS + 1)'(JROUND);

  assign tx_inc = tx_cnt_q + 1'b1;

  // result fields
  assign lost_v = ((tx_cnt_q != '0) && (tx_cnt_q >= rx_cnt_q)) ? (tx_cnt_q - rx_cnt_q) : '0;
  assign mean_v = (rx_cnt_q == '0) ? '0 :
                  ((|quo[DW-1:TIME_BITS]) ? '1 : quo[TIME_BITS-1:0]);
  assign act_v  = (rx_cnt_q == '0) ? '0 : ({1'b0, last_rx_q} - {1'b0, first_tx_q});

  // the output slot takes the result once it is empty or being emptied
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || res_o.ready);
  assign out_valid_d = out_load | (out_valid_q & ~res_o.ready);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    div_ctrl.start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (evt_i.valid) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        state_d = (func_q == fsrj_pkg::FUNC_RX) ? S_SER : S_DIV;
      end
      S_SER: begin
        if (ser_last) begin
          state_d = S_MAG;
        end
      end
      S_MAG:   state_d = S_JDIF;
      S_JDIF:  state_d = S_JSTEP;
      S_JSTEP: state_d = S_JUPD;
      S_JUPD:  state_d = S_DIV;
      S_DIV: begin
        div_ctrl.start = 1'b1;
        state_d        = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_stat.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // flow state and control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tx_cnt_q     <= '0;
      tx_byt_q     <= '0;
      rx_cnt_q     <= '0;
      rx_byt_q     <= '0;
      first_tx_q   <= '0;
      last_rx_q    <= '0;
      last_stamp_q <= '0;
      jit_q        <= '0;
      dsum_q       <= '0;
      scnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        S_UPD: begin
          scnt_q <= '0;
          case (func_q)
            fsrj_pkg::FUNC_TX: begin
              tx_cnt_q <= tx_inc;
              tx_byt_q <= tx_byt_q + bytes_q;
              // first transmit, also after the counter wraps round
              if (tx_inc == COUNT_BITS'(1)) begin
                first_tx_q <= now_q;
              end
            end
            fsrj_pkg::FUNC_RX: begin
              rx_cnt_q     <= rx_cnt_q + 1'b1;
              rx_byt_q     <= rx_byt_q + bytes_q;
              // old values already copied into the serial operands
              last_rx_q    <= now_q;
              last_stamp_q <= sent_q;
            end
            fsrj_pkg::FUNC_CLR: begin
              tx_cnt_q     <= '0;
              tx_byt_q     <= '0;
              rx_cnt_q     <= '0;
              rx_byt_q     <= '0;
              jit_q        <= '0;
              dsum_q       <= '0;
              first_tx_q   <= now_q;
              last_rx_q    <= now_q;
              last_stamp_q <= now_q;
            end
            fsrj_pkg::FUNC_NOP: begin
              // unused kind only reports
            end
            default: begin
            end
          endcase
        end
        S_SER: begin
          scnt_q <= scnt_q + 1'b1;
        end
        S_MAG: begin
          // negative delay adds nothing
          if (!bw_q) begin
            dsum_q <= cand_sh_q[DW-1:0];
          end
        end
        S_JUPD: begin
          jit_q <= ge_q ? (jit_q + step_q) : (jit_q - step_q);
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // item capture, serial datapath, jitter pipeline and output payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      func_q  <= fsrj_pkg::func_e'(evt_i.func);
      bytes_q <= COUNT_BITS'(evt_i.byte_count);
      now_q   <= evt_i.now_time;
      sent_q  <= evt_i.sent_time;
    end

    case (state_q)
      S_UPD: begin
        now_sh_q   <= SER_BITS'(now_q);
        sent_sh_q  <= SER_BITS'(sent_q);
        rx_sh_q    <= SER_BITS'(last_rx_q);
        stamp_sh_q <= SER_BITS'(last_stamp_q);
        dsum_sh_q  <= SER_BITS'(dsum_q);
        ca_q       <= 1'b0;
        cb_q       <= 1'b0;
        bd_q       <= 1'b0;
        bw_q       <= 1'b0;
        cc_q       <= 1'b0;
      end
      S_SER: begin
        now_sh_q   <= {1'b0, now_sh_q[SER_BITS-1:1]};
        sent_sh_q  <= {1'b0, sent_sh_q[SER_BITS-1:1]};
        rx_sh_q    <= {1'b0, rx_sh_q[SER_BITS-1:1]};
        stamp_sh_q <= {1'b0, stamp_sh_q[SER_BITS-1:1]};
        dsum_sh_q  <= {1'b0, dsum_sh_q[SER_BITS-1:1]};
        d_sh_q     <= {d_b, d_sh_q[SER_BITS-1:1]};
        cand_sh_q  <= {c_b, cand_sh_q[SER_BITS-1:1]};
        ca_q       <= ca_d;
        cb_q       <= cb_d;
        bd_q       <= bd_d;
        bw_q       <= bw_d;
        cc_q       <= cc_d;
      end
      S_MAG: begin
        mag_q <= mag_d;
      end
      S_JDIF: begin
        ge_q <= ~sub_mj[TIME_BITS];
        jd_q <= sub_mj[TIME_BITS] ? (jit_q - mag_q) : sub_mj[TIME_BITS-1:0];
      end
      S_JSTEP: begin
        // a fall's difference is biased up before the logical shift, so its step rounds away from zero
        step_q <= ge_q ? (jd_q >> JS) : TIME_BITS'(rnd >> JS);
      end
      default: begin
      end
    endcase

    if (out_load) begin
      o_txi_q  <= to_out(tx_cnt_q - 1'b1);
      o_txp_q  <= to_out(tx_cnt_q);
      o_txb_q  <= to_out(tx_byt_q);
      o_rxp_q  <= to_out(rx_cnt_q);
      o_rxb_q  <= to_out(rx_byt_q);
      o_lost_q <= to_out(lost_v);
      o_jit_q  <= jit_q;
      o_mean_q <= mean_v;
      o_act_q  <= act_v;
    end
  end

  // mean delay divider
  fsrj_div #(
    .NUM_BITS (DW),
    .DEN_BITS (COUNT_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (dsum_q),
    .den_i  (rx_cnt_q),
    .stat_o (div_stat),
    .quo_o  (quo)
  );

  assign res_o.valid        = out_valid_q;
  assign res_o.tx_index     = o_txi_q;
  assign res_o.tx_packets   = o_txp_q;
  assign res_o.tx_bytes     = o_txb_q;
  assign res_o.rx_packets   = o_rxp_q;
  assign res_o.rx_bytes     = o_rxb_q;
  assign res_o.lost_packets = o_lost_q;
  assign res_o.jitter       = o_jit_q;
  assign res_o.mean_delay   = o_mean_q;
  assign res_o.active_time  = $signed(o_act_q);

  `FSRJ_ASSERT(a_accept_upd, evt_i.valid && evt_i.ready |=> state_q == S_UPD,
               "accepted item did not start an update")
  `FSRJ_ASSERT(a_ser_end, state_q == S_SER && ser_last |=> state_q == S_MAG,
               "serial pass overran its length")
  `FSRJ_ASSERT(a_div_done, div_stat.done |-> state_q == S_DWAIT,
               "divider finished outside its wait state")
  `FSRJ_ASSERT(a_out_load, out_load |=> out_valid_q && state_q == S_IDLE,
               "result not held after loading")

endmodule

`default_nettype wire

// File: verif/tb_flow_stats_rtp_jitter.sv
// self-checking testbench for flow_stats_rtp_jitter: counters, jitter, mean delay, active time
// depends on fsrj_pkg, the fsrj_evt_if / fsrj_res_if interfaces and the block itself

module tb_flow_stats_rtp_jitter;
  timeunit 1ns;
  timeprecision 1ps;

  import fsrj_pkg::*;

  localparam int TW = TIME_BITS_DEF;
  localparam int CW = OUT_CNT_BITS;
  localparam logic [TW-1:0] TIME_MAX = '1;

  // random part: items per idling phase, and how each phase idles
  localparam int ITEMS_PER_PHASE = 400;
  localparam int SRC_IDLE_PCT [4] = '{0, 66, 0, 27};
  localparam int SNK_STALL_PCT [4] = '{0, 0, 66, 27};

  // one input item as the sender sees it
  typedef struct {
    func_e         func;
    logic [15:0]   byte_count;
    logic [TW-1:0] now_time;
    logic [TW-1:0] sent_time;
  } flow_evt_t;

  // one result item: statistics as they stand after an event
  typedef struct {
    logic [CW-1:0]      tx_index;
    logic [CW-1:0]      tx_packets;
    logic [CW-1:0]      tx_bytes;
    logic [CW-1:0]      rx_packets;
    logic [CW-1:0]      rx_bytes;
    logic [CW-1:0]      lost_packets;
    logic [TW-1:0]      jitter;
    logic [TW-1:0]      mean_delay;
    logic signed [TW:0] active_time;
  } flow_stats_t;

  // keeps its own copy of the flow state, works out the statistics each accepted
  // item should produce and compares the block's results against them in order
  class flow_stats_tracker;
    logic [CW-1:0] tx_cnt, tx_octets, rx_cnt, rx_octets;
    logic [TW-1:0] first_tx_t, last_rx_t, last_stamp, jit;
    logic [63:0]   delay_sum;
    flow_stats_t   expected_stats[$];
    int            mismatch_count;

    function new();
      clear_flow('0);
      mismatch_count = 0;
    endfunction

    // a reset event clears everything and pins the three times to the event time
    function void clear_flow(logic [TW-1:0] t);
      tx_cnt     = '0;
      tx_octets  = '0;
      rx_cnt     = '0;
      rx_octets  = '0;
      first_tx_t = t;
      last_rx_t  = t;
      last_stamp = t;
      jit        = '0;
      delay_sum  = '0;
    endfunction

    function int pending();
      return expected_stats.size();
    endfunction

    function void note_event(flow_evt_t e);
      logic [TW+1:0] sum_a, sum_b, dmag;
      logic [TW+3:0] jnext;
      logic [63:0]   quot;
      flow_stats_t   s;
      case (e.func)
        FUNC_TX: begin
          tx_cnt    = tx_cnt + 1'b1;
          tx_octets = tx_octets + CW'(e.byte_count);
          // first transmit, also after the count wraps round
          if (tx_cnt == CW'(1)) first_tx_t = e.now_time;
        end
        FUNC_RX: begin
          rx_cnt    = rx_cnt + 1'b1;
          rx_octets = rx_octets + CW'(e.byte_count);
          // |(now - last_rx) - (sent - last_stamp)| taken as a difference of two sums
          sum_a = {2'b00, e.now_time} + {2'b00, last_stamp};
          sum_b = {2'b00, last_rx_t} + {2'b00, e.sent_time};
          dmag  = (sum_a >= sum_b) ? sum_a - sum_b : sum_b - sum_a;
          if (dmag > {2'b00, TIME_MAX}) dmag = {2'b00, TIME_MAX};
          // jitter moves a sixteenth of the way; floor shift rounds a fall upwards
          if (dmag >= {2'b00, jit})
            jnext = {4'b0, jit} + (({2'b00, dmag} - {4'b0, jit}) >> JITTER_SHIFT);
          else
            jnext = {4'b0, jit} - (({4'b0, jit} - {2'b00, dmag} + (TW+4)'(15)) >> JITTER_SHIFT);
          jit        = jnext[TW-1:0];
          last_rx_t  = e.now_time;
          last_stamp = e.sent_time;
          // negative delay adds nothing
          if (e.now_time >= e.sent_time) delay_sum = delay_sum + 64'(e.now_time - e.sent_time);
        end
        FUNC_CLR: clear_flow(e.now_time);
        default: ;
      endcase

      s.tx_index     = tx_cnt - 1'b1;
      s.tx_packets   = tx_cnt;
      s.tx_bytes     = tx_octets;
      s.rx_packets   = rx_cnt;
      s.rx_bytes     = rx_octets;
      s.lost_packets = (tx_cnt != '0 && tx_cnt >= rx_cnt) ? tx_cnt - rx_cnt : '0;
      s.jitter       = jit;
      s.mean_delay   = '0;
      s.active_time  = '0;
      if (rx_cnt != '0) begin
        quot         = delay_sum / {{(64-CW){1'b0}}, rx_cnt};
        s.mean_delay = (quot > 64'(TIME_MAX)) ? TIME_MAX : quot[TW-1:0];
        s.active_time = {1'b0, last_rx_t} - {1'b0, first_tx_t};
      end
      expected_stats.push_back(s);
    endfunction

    function bit field_bad(string name, logic [63:0] want, logic [63:0] got);
      if (got === want) return 1'b0;
      if (mismatch_count < 10)
        $display("%t: %s expected %h, got %h", $realtime, name, want, got);
      return 1'b1;
    endfunction

    function void check_stats(flow_stats_t got);
      flow_stats_t want;
      bit          bad;
      if (expected_stats.size() == 0) begin
        if (mismatch_count < 10) $display("%t: result with nothing outstanding", $realtime);
        mismatch_count++;
        return;
      end
      want = expected_stats.pop_front();
      bad  = 1'b0;
      bad |= field_bad("tx_index", 64'(want.tx_index), 64'(got.tx_index));
      bad |= field_bad("tx_packets", 64'(want.tx_packets), 64'(got.tx_packets));
      bad |= field_bad("tx_bytes", 64'(want.tx_bytes), 64'(got.tx_bytes));
      bad |= field_bad("rx_packets", 64'(want.rx_packets), 64'(got.rx_packets));
      bad |= field_bad("rx_bytes", 64'(want.rx_bytes), 64'(got.rx_bytes));
      bad |= field_bad("lost_packets", 64'(want.lost_packets), 64'(got.lost_packets));
      bad |= field_bad("jitter", 64'(want.jitter), 64'(got.jitter));
      bad |= field_bad("mean_delay", 64'(want.mean_delay), 64'(got.mean_delay));
      bad |= field_bad("active_time", 64'(want.active_time), 64'(got.active_time));
      if (bad) mismatch_count++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  fsrj_evt_if evt_if ();
  fsrj_res_if res_if ();

  flow_stats_rtp_jitter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  flow_stats_tracker stats_board = new();

  // current idling of each side, changed per phase by the stimulus
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;

  // running time of the synthetic flow, so most events look like a real stream
  logic [TW-1:0] flow_clock = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // generous bound on the whole run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic flow_evt_t mk_evt(func_e f, logic [15:0] b, logic [TW-1:0] n,
                                       logic [TW-1:0] s);
    flow_evt_t e;
    e.func       = f;
    e.byte_count = b;
    e.now_time   = n;
    e.sent_time  = s;
    return e;
  endfunction

  function automatic logic [TW-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[TW-1:0];
  endfunction

  // mostly an orderly stream of transmits and receives with realistic delays,
  // the rest full-range times, late stamps, counter resets and unused codes
  function automatic flow_evt_t random_event();
    flow_evt_t e;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 46)      e.func = FUNC_TX;
    else if (pick < 92) e.func = FUNC_RX;
    else if (pick < 96) e.func = FUNC_CLR;
    else                e.func = FUNC_NOP;

    e.byte_count = ($urandom_range(99) < 20) ? 16'($urandom()) : 16'($urandom_range(40, 1500));

    pick = $urandom_range(99);
    if (pick < 85) begin
      // in-order flow: time moves on, stamp lags by the network delay
      flow_clock  = flow_clock + TW'($urandom_range(1, 5000));
      e.now_time  = flow_clock;
      e.sent_time = flow_clock - TW'($urandom_range(0, 20000));
    end else if (pick < 90) begin
      // stamp ahead of the receive time, delay clamps to zero
      flow_clock  = flow_clock + TW'($urandom_range(1, 5000));
      e.now_time  = flow_clock;
      e.sent_time = flow_clock + TW'($urandom_range(1, 3000));
    end else begin
      e.now_time  = rand_time();
      e.sent_time = rand_time();
      if ($urandom_range(1) == 1) flow_clock = e.now_time;
    end
    return e;
  endfunction

  // presents one item, with random idle cycles first, and notes it once accepted;
  // valid is only lowered when an idle cycle follows, never dropped between items
  task automatic send_event(flow_evt_t e);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_if.valid      <= 1'b1;
    evt_if.func       <= e.func;
    evt_if.byte_count <= e.byte_count;
    evt_if.now_time   <= e.now_time;
    evt_if.sent_time  <= e.sent_time;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    stats_board.note_event(e);
  endtask

  task automatic run_directed();
    // unused code before anything happened: tx_index wraps to all ones
    send_event(mk_evt(FUNC_NOP, 16'h0000, TW'(5), TW'(0)));
    // receive with no transmit yet: nothing counted as lost
    send_event(mk_evt(FUNC_RX, 16'd64, TW'(100), TW'(40)));
    // smallest and largest packets
    send_event(mk_evt(FUNC_TX, 16'h0000, TW'(200), TW'(0)));
    send_event(mk_evt(FUNC_TX, 16'hFFFF, TW'(210), TW'(0)));
    send_event(mk_evt(FUNC_RX, 16'hFFFF, TW'(300), TW'(250)));
    // stamp later than arrival: delay clamps to zero
    send_event(mk_evt(FUNC_RX, 16'd100, TW'(290), TW'(320)));
    // swing the times to the extremes so |D| runs past the time range both ways
    send_event(mk_evt(FUNC_RX, 16'd1, TW'(0), TIME_MAX));
    send_event(mk_evt(FUNC_RX, 16'd1, TIME_MAX, TW'(0)));
    send_event(mk_evt(FUNC_RX, 16'd1, TW'(0), TIME_MAX));
    // steady delay after that: the estimate decays, rounding each fall upwards
    send_event(mk_evt(FUNC_RX, 16'd500, TW'(1000), TW'(900)));
    send_event(mk_evt(FUNC_RX, 16'd500, TW'(2000), TW'(1900)));
    send_event(mk_evt(FUNC_RX, 16'd500, TW'(3000), TW'(2900)));
    send_event(mk_evt(FUNC_RX, 16'd500, TW'(4000), TW'(3900)));
    // counter reset, then a fresh first transmit
    send_event(mk_evt(FUNC_CLR, 16'd77, TW'(5000), TW'(123)));
    send_event(mk_evt(FUNC_TX, 16'd1500, TW'(5100), TW'(0)));
    send_event(mk_evt(FUNC_RX, 16'd1500, TW'(5200), TW'(5150)));
    // more receives than transmits
    send_event(mk_evt(FUNC_RX, 16'd40, TW'(5300), TW'(5290)));
    send_event(mk_evt(FUNC_RX, 16'd40, TW'(5400), TW'(5390)));
    // reset at the top of the time range, unused code with every field at its top
    send_event(mk_evt(FUNC_CLR, 16'hFFFF, TIME_MAX, TIME_MAX));
    send_event(mk_evt(FUNC_NOP, 16'hFFFF, TIME_MAX, TIME_MAX));
    // first transmit after the last receive: active time goes negative
    send_event(mk_evt(FUNC_TX, 16'd200, TW'(1_000_000), TW'(0)));
    send_event(mk_evt(FUNC_RX, 16'd200, TW'(500), TW'(400)));
    send_event(mk_evt(FUNC_TX, 16'd200, TW'(1_000_100), TW'(0)));
    send_event(mk_evt(FUNC_CLR, 16'd0, TW'(0), TW'(0)));
  endtask

  // result side: check every accepted result, stall at random
  initial begin : result_sink
    flow_stats_t got;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        got.tx_index     = res_if.tx_index;
        got.tx_packets   = res_if.tx_packets;
        got.tx_bytes     = res_if.tx_bytes;
        got.rx_packets   = res_if.rx_packets;
        got.rx_bytes     = res_if.rx_bytes;
        got.lost_packets = res_if.lost_packets;
        got.jitter       = res_if.jitter;
        got.mean_delay   = res_if.mean_delay;
        got.active_time  = res_if.active_time;
        stats_board.check_stats(got);
      end
      res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // stimulus: reset, directed items, four idling phases of random items, drain
  initial begin : stimulus
    flow_evt_t e;
    int        counted;
    rst_ni               = 1'b0;
    evt_if.valid         = 1'b0;
    evt_if.func          = FUNC_NOP;
    evt_if.byte_count    = '0;
    evt_if.now_time      = '0;
    evt_if.sent_time     = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = SRC_IDLE_PCT[ph];
      snk_stall_pct = SNK_STALL_PCT[ph];
      counted = 0;
      // unused codes change nothing, so they do not count towards the phase
      while (counted < ITEMS_PER_PHASE) begin
        e = random_event();
        send_event(e);
        if (e.func != FUNC_NOP) counted++;
      end
    end
    evt_if.valid <= 1'b0;

    // drain outstanding results, then watch a little longer for strays
    while (stats_board.pending() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    if (stats_board.mismatch_count == 0 && stats_board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
